[rtl/ffpa_pkg.sv]
// Shared types and constants for the first-fit page allocator.
package ffpa_pkg;

    // Geometry of the managed region
    localparam int TABLE_PAGES = 1024;
    localparam int PAGE_BITS   = 12;
    localparam int IDX_W       = $clog2(TABLE_PAGES); // page index
    localparam int CNT_W       = IDX_W + 1;           // page count, 0..TABLE_PAGES
    localparam int ENT_W       = CNT_W + 1;           // page table entry
    localparam int BYTE_W      = 23;                  // byte_count field
    localparam int OFS_W       = 22;                  // byte offset fields
    localparam int LOC_W       = OFS_W - PAGE_BITS;   // page index taken from an offset
    localparam int NEED_W      = BYTE_W - PAGE_BITS + 1;

    // Page table entry codes: zero is free, all ones marks a continuation
    localparam logic [ENT_W-1:0] ENT_FREE  = '0;
    localparam logic [ENT_W-1:0] CONT_MARK = '1;

    // Region size register value after reset
    localparam logic [CNT_W-1:0] TOTAL_PAGES_RST = CNT_W'(1024);

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADSIZE = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef struct packed {
        logic [0:0]        req_type;
        logic [BYTE_W-1:0] byte_count;
        logic [OFS_W-1:0]  free_offset;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFS_W-1:0] alloc_offset;
        logic [CNT_W-1:0] pages_done;
    } t_out;

    // Engine status toward the top level
    typedef struct packed {
        logic ready;    // idle, can take a request
        logic done;     // result held on the result bus
    } t_eng_stat;

endpackage

[rtl/ffpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ffpa_engine.sv]
// Sequencer that walks the page table: clearing pass, first-fit scan, mark and free.
module ffpa_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  ffpa_pkg::t_in              i_req,
    input  logic [ffpa_pkg::CNT_W-1:0] i_total_pages,
    input  logic                       i_res_ready,
    output ffpa_pkg::t_eng_stat        o_stat,
    output ffpa_pkg::t_out             o_res
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FCHK,
        S_FCLR,
        S_RES
    } t_state;

    t_state                        r_state, n_state;
    logic [ffpa_pkg::CNT_W-1:0]    r_ptr, n_ptr;        // next page to read in the scan
    logic                          r_chk_vld, n_chk_vld;
    logic [ffpa_pkg::IDX_W-1:0]    r_chk_idx, n_chk_idx;
    logic [ffpa_pkg::CNT_W-1:0]    r_run, n_run;        // free pages seen in a row
    logic [ffpa_pkg::CNT_W-1:0]    r_need, n_need;
    logic [ffpa_pkg::CNT_W-1:0]    r_cnt, n_cnt;        // writes left
    logic [ffpa_pkg::IDX_W-1:0]    r_wptr, n_wptr;
    logic                          r_first, n_first;
    ffpa_pkg::t_out                r_res, n_res;

    logic                          mem_we;
    logic [ffpa_pkg::IDX_W-1:0]    mem_waddr;
    logic [ffpa_pkg::ENT_W-1:0]    mem_wdata;
    logic [ffpa_pkg::IDX_W-1:0]    mem_raddr;
    logic [ffpa_pkg::ENT_W-1:0]    mem_rdata;

    logic [ffpa_pkg::CNT_W-1:0]    n_eff;
    logic [ffpa_pkg::NEED_W-1:0]   need_pages;
    logic [ffpa_pkg::LOC_W-1:0]    free_loc;
    logic [ffpa_pkg::CNT_W-1:0]    run_inc;
    logic                          ent_free;
    logic [ffpa_pkg::IDX_W-1:0]    found_start;

    // Page table
    ffpa_ram #(
        .WIDTH (ffpa_pkg::ENT_W),
        .DEPTH (ffpa_pkg::TABLE_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Request decode
    assign n_eff = (i_total_pages < ffpa_pkg::CNT_W'(ffpa_pkg::TABLE_PAGES))
                 ? i_total_pages : ffpa_pkg::CNT_W'(ffpa_pkg::TABLE_PAGES);
    assign need_pages = {1'b0, i_req.byte_count[ffpa_pkg::BYTE_W-1:ffpa_pkg::PAGE_BITS]}
                      + ffpa_pkg::NEED_W'(|i_req.byte_count[ffpa_pkg::PAGE_BITS-1:0]);
    assign free_loc   = i_req.free_offset[ffpa_pkg::OFS_W-1:ffpa_pkg::PAGE_BITS];

    // Scan datapath: one counter add and compare per table entry
    assign ent_free    = (mem_rdata == ffpa_pkg::ENT_FREE);
    assign run_inc     = r_run + ffpa_pkg::CNT_W'(1);
    assign found_start = r_chk_idx + ffpa_pkg::IDX_W'(1) - r_need[ffpa_pkg::IDX_W-1:0];

    // Table write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wptr;
        mem_wdata = ffpa_pkg::ENT_FREE;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = (r_wptr == '0) ? ffpa_pkg::ENT_W'(1) : ffpa_pkg::ENT_FREE;
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = r_first ? ffpa_pkg::ENT_W'(r_need) : ffpa_pkg::CONT_MARK;
            end
            S_FCLR: begin
                mem_we    = 1'b1;
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    // Table read address: head lookup on a free request, otherwise the scan pointer
    assign mem_raddr = (r_state == S_IDLE) ? free_loc[ffpa_pkg::IDX_W-1:0]
                                           : r_ptr[ffpa_pkg::IDX_W-1:0];

    // Sequencer next state
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_chk_vld = r_chk_vld;
        n_chk_idx = r_chk_idx;
        n_run     = r_run;
        n_need    = r_need;
        n_cnt     = r_cnt;
        n_wptr    = r_wptr;
        n_first   = r_first;
        n_res     = r_res;
        case (r_state)
            S_CLEAR: begin
                n_wptr = r_wptr + ffpa_pkg::IDX_W'(1);
                if (&r_wptr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_res = '0;
                    if (i_req.req_type == ffpa_pkg::REQ_ALLOC) begin
                        if (need_pages == '0 || need_pages > {1'b0, n_eff}) begin
                            n_res.status = ffpa_pkg::ST_BADSIZE;
                            n_state      = S_RES;
                        end else begin
                            n_need    = need_pages[ffpa_pkg::CNT_W-1:0];
                            n_ptr     = '0;
                            n_chk_vld = 1'b0;
                            n_run     = '0;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (ffpa_pkg::CNT_W'(free_loc) >= n_eff) begin
                            n_res.status = ffpa_pkg::ST_BADFREE;
                            n_state      = S_RES;
                        end else begin
                            n_wptr  = free_loc[ffpa_pkg::IDX_W-1:0];
                            n_state = S_FCHK;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_vld && ent_free && run_inc == r_need) begin
                    // window of free pages complete: its start is the first fit
                    n_wptr             = found_start;
                    n_cnt              = r_need;
                    n_first            = 1'b1;
                    n_res.status       = ffpa_pkg::ST_OK;
                    n_res.alloc_offset = {found_start, ffpa_pkg::PAGE_BITS'(0)};
                    n_res.pages_done   = r_need;
                    n_state            = S_MARK;
                end else begin
                    if (r_chk_vld) begin
                        n_run = ent_free ? run_inc : '0;
                    end
                    if (r_ptr < n_eff) begin
                        n_chk_vld = 1'b1;
                        n_chk_idx = r_ptr[ffpa_pkg::IDX_W-1:0];
                        n_ptr     = r_ptr + ffpa_pkg::CNT_W'(1);
                    end else begin
                        n_chk_vld = 1'b0;
                        if (!r_chk_vld) begin
                            n_res.status = ffpa_pkg::ST_NOSPACE;
                            n_state      = S_RES;
                        end
                    end
                end
            end
            S_MARK: begin
                n_first = 1'b0;
                n_cnt   = r_cnt - ffpa_pkg::CNT_W'(1);
                n_wptr  = r_wptr + ffpa_pkg::IDX_W'(1);
                if (r_cnt == ffpa_pkg::CNT_W'(1)) begin
                    n_state = S_RES;
                end
            end
            S_FCHK: begin
                if (mem_rdata == ffpa_pkg::ENT_FREE || mem_rdata == ffpa_pkg::CONT_MARK) begin
                    n_res.status = ffpa_pkg::ST_BADFREE;
                    n_state      = S_RES;
                end else begin
                    n_cnt            = mem_rdata[ffpa_pkg::CNT_W-1:0];
                    n_res.status     = ffpa_pkg::ST_OK;
                    n_res.pages_done = mem_rdata[ffpa_pkg::CNT_W-1:0];
                    n_state          = S_FCLR;
                end
            end
            S_FCLR: begin
                // stop at the run's end or the last table entry
                n_cnt  = r_cnt - ffpa_pkg::CNT_W'(1);
                n_wptr = r_wptr + ffpa_pkg::IDX_W'(1);
                if (r_cnt == ffpa_pkg::CNT_W'(1) || (&r_wptr)) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_wptr    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wptr    <= n_wptr;
            r_chk_vld <= n_chk_vld;
        end
        r_ptr     <= n_ptr;
        r_chk_idx <= n_chk_idx;
        r_run     <= n_run;
        r_need    <= n_need;
        r_cnt     <= n_cnt;
        r_first   <= n_first;
        r_res     <= n_res;
    end

    assign o_stat.ready = (r_state == S_IDLE);
    assign o_stat.done  = (r_state == S_RES);
    assign o_res        = r_res;

`ifndef SYNTHESIS
    // The scan only reads the table
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("page table written during scan");

    // A run of free pages never reaches the target length without leaving the scan
    a_run_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_need))
        else $error("free run counter overran request length");

    // Error results carry no offset and no page count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && r_res.status != ffpa_pkg::ST_OK)
        |-> (r_res.alloc_offset == '0 && r_res.pages_done == '0))
        else $error("error result with nonzero payload");

    // A held result stays put until taken
    a_res_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && !i_res_ready) |=> (o_stat.done && $stable(r_res)))
        else $error("result dropped or changed before handoff");

    // Clearing pass ends after the last entry
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && (&r_wptr)) |=> (r_state == S_IDLE))
        else $error("clearing pass did not finish at table end");
`endif

endmodule

[rtl/first_fit_page_allocator.sv]
// Top level of the first-fit page allocator: request and result channels, config register.
//
// Request channel (i_in_*): one beat per alloc or free request, taken when
// i_in_valid is high and o_in_stall is low. Result channel (o_out_*): exactly
// one beat per request, taken when o_out_valid is high and i_out_stall is low.
// Config: i_cfg_we writes total_pages from i_cfg_data; write only while idle.
//
// Each request is handled by one sequencer walking a 1024-entry page table
// through a single read and a single write port, one entry per cycle. The
// region is total_pages capped at 1024. An alloc scans up to the end of the
// first fit, then marks the run; with no fit it scans the whole region. A
// free reads the head entry, then clears the run. A bad size, an out-of-range
// free and a free of a free or continuation page are answered with no walk.
// o_in_stall is high while a request is in work; one request at a time.
// After reset a clearing pass writes all 1024 table entries with o_in_stall
// high; config writes are taken throughout. Page 0 comes out reserved.
// The result sits in an output register; while the receiver stalls it holds,
// the next request may still be taken, and its result waits in the engine.
module first_fit_page_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ffpa_pkg::t_in              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ffpa_pkg::t_out             o_out_data,
    input  logic                       i_cfg_we,
    input  logic [ffpa_pkg::CNT_W-1:0] i_cfg_data
);

    logic [ffpa_pkg::CNT_W-1:0] r_total_pages;
    logic                       r_out_valid, n_out_valid;
    ffpa_pkg::t_out             r_out_data, n_out_data;

    ffpa_pkg::t_eng_stat        eng_stat;
    ffpa_pkg::t_out             eng_res;
    logic                       res_ready;
    logic                       start;

    assign start     = i_in_valid && eng_stat.ready;
    assign res_ready = !r_out_valid || !i_out_stall;

    ffpa_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_req         (i_in_data),
        .i_total_pages (r_total_pages),
        .i_res_ready   (res_ready),
        .o_stat        (eng_stat),
        .o_res         (eng_res)
    );

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= ffpa_pkg::TOTAL_PAGES_RST;
        end else if (i_cfg_we) begin
            r_total_pages <= i_cfg_data;
        end
    end

    // Output register: load on handoff, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (eng_stat.done && res_ready) begin
            n_out_valid = 1'b1;
            n_out_data  = eng_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = !eng_stat.ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[bench/testbench.sv]
// Self-checking bench for the first-fit page allocator: random traffic against a page table model.
`timescale 1ns / 1ps

module testbench;

    localparam int PAGE_SIZE   = 1 << ffpa_pkg::PAGE_BITS;
    localparam int RUN_BODY    = -1;       // continuation page inside a run
    localparam int STALL_LIMIT = 20000;    // cycles without any beat before giving up
    localparam int TAIL_CYCLES = 2100;     // longest table walk plus margin

    // One queued request; to_live asks the driver to aim the free at a live run
    typedef struct {
        ffpa_pkg::t_in beat;
        bit            to_live;
    } t_req_slot;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ffpa_pkg::t_in              in_data   = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    ffpa_pkg::t_out             out_data;
    logic                       cfg_we    = 1'b0;
    logic [ffpa_pkg::CNT_W-1:0] cfg_data  = '0;

    t_req_slot      pending_q [$];
    ffpa_pkg::t_out due_replies [$];

    // Shadow of the block: page table and region register
    int                         page_map [ffpa_pkg::TABLE_PAGES];
    logic [ffpa_pkg::CNT_W-1:0] region_cfg = ffpa_pkg::TOTAL_PAGES_RST;

    int  in_gap      = 0;
    int  out_hold    = 0;
    bit  in_steady   = 1'b0;
    bit  out_steady  = 1'b0;
    int  mismatches  = 0;
    int  quiet_count = 0;
    int  n_requests  = 0;
    int  n_placed    = 0;
    int  n_released  = 0;
    int  n_nospace   = 0;
    int  n_badsize   = 0;
    int  n_badfree   = 0;
    int  n_regions   = 0;

    first_fit_page_allocator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow table and return the result it must give
    function automatic ffpa_pkg::t_out serve_request(ffpa_pkg::t_in req);
        ffpa_pkg::t_out res;
        int   region, need, run, found, p, len, loc;
        res    = '0;
        region = (int'(region_cfg) < ffpa_pkg::TABLE_PAGES) ? int'(region_cfg)
                                                             : ffpa_pkg::TABLE_PAGES;
        n_requests++;
        if (req.req_type == ffpa_pkg::REQ_ALLOC) begin
            need = (int'(req.byte_count) + PAGE_SIZE - 1) >> ffpa_pkg::PAGE_BITS;
            if (need == 0 || need > region) begin
                res.status = ffpa_pkg::ST_BADSIZE;
                n_badsize++;
            end else begin
                // first fit: stop at the first window of need free pages
                run   = 0;
                found = -1;
                for (p = 0; p < region && found < 0; p++) begin
                    run = (page_map[p] == 0) ? run + 1 : 0;
                    if (run == need) found = p - need + 1;
                end
                if (found < 0) begin
                    res.status = ffpa_pkg::ST_NOSPACE;
                    n_nospace++;
                end else begin
                    page_map[found] = need;
                    for (p = found + 1; p < found + need; p++) page_map[p] = RUN_BODY;
                    res.status       = ffpa_pkg::ST_OK;
                    res.alloc_offset = ffpa_pkg::OFS_W'(found << ffpa_pkg::PAGE_BITS);
                    res.pages_done   = ffpa_pkg::CNT_W'(need);
                    n_placed++;
                end
            end
        end else begin
            loc = int'(req.free_offset >> ffpa_pkg::PAGE_BITS);
            len = (loc < region) ? page_map[loc] : 0;
            if (len <= 0) begin
                res.status = ffpa_pkg::ST_BADFREE;
                n_badfree++;
            end else begin
                // clear the run, never past the table end
                for (p = loc; p < loc + len && p < ffpa_pkg::TABLE_PAGES; p++) page_map[p] = 0;
                res.status     = ffpa_pkg::ST_OK;
                res.pages_done = ffpa_pkg::CNT_W'(len);
                n_released++;
            end
        end
        return res;
    endfunction

    // Byte offset inside a random live run, or anywhere when the table is empty
    function automatic logic [ffpa_pkg::OFS_W-1:0] live_run_offset();
        int heads [$];
        int p;
        for (p = 0; p < ffpa_pkg::TABLE_PAGES; p++) begin
            if (page_map[p] > 0) heads.push_back(p);
        end
        if (heads.size() == 0) return ffpa_pkg::OFS_W'($urandom);
        p = heads[$urandom_range(0, heads.size() - 1)];
        return {ffpa_pkg::LOC_W'(p), ffpa_pkg::PAGE_BITS'($urandom)};
    endfunction

    function automatic void queue_beat(logic kind, int bytes, int offset, bit to_live = 1'b0);
        t_req_slot slot;
        slot.beat.req_type    = kind;
        slot.beat.byte_count  = ffpa_pkg::BYTE_W'(bytes);
        slot.beat.free_offset = ffpa_pkg::OFS_W'(offset);
        slot.to_live          = to_live;
        pending_q.push_back(slot);
    endfunction

    task automatic flag_mismatch(string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Region write, only once every request has been answered
    task automatic set_region(int pages);
        wait (pending_q.size() == 0 && due_replies.size() == 0);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= ffpa_pkg::CNT_W'(pages);
        @(posedge clk);
        cfg_we     <= 1'b0;
        region_cfg  = ffpa_pkg::CNT_W'(pages);
        in_steady   = ($urandom_range(0, 3) == 0);
        out_steady  = ($urandom_range(0, 3) == 0);
        n_regions++;
    endtask

    // Request driver: random gap before each beat (none in steady phases), payload held while stalled
    always @(posedge clk) begin : req_drive
        bit        taken;
        t_req_slot slot;
        if (!rst_n) begin
            for (int p = 0; p < ffpa_pkg::TABLE_PAGES; p++) page_map[p] = 0;
            page_map[0] = 1;
            region_cfg  = ffpa_pkg::TOTAL_PAGES_RST;
            in_gap      = 0;
            in_valid   <= 1'b0;
        end else begin
            taken = in_valid && !in_stall;
            if (taken) begin
                due_replies.push_back(serve_request(in_data));
                void'(pending_q.pop_front());
                in_gap = in_steady ? 0 : $urandom_range(0, 7);
            end
            if (!in_valid || taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    slot = pending_q[0];
                    if (slot.to_live) slot.beat.free_offset = live_run_offset();
                    in_data  <= slot.beat;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random stall after each beat (none in steady phases), field-wise compare
    always @(posedge clk) begin : reply_check
        ffpa_pkg::t_out want;
        if (!rst_n) begin
            out_hold   = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_replies.size() == 0) begin
                    flag_mismatch("result beat with no request outstanding");
                end else begin
                    want = due_replies.pop_front();
                    if (out_data.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                out_data.status, want.status));
                    if (out_data.alloc_offset !== want.alloc_offset)
                        flag_mismatch($sformatf("alloc_offset 0x%0h, expected 0x%0h",
                                                out_data.alloc_offset, want.alloc_offset));
                    if (out_data.pages_done !== want.pages_done)
                        flag_mismatch($sformatf("pages_done %0d, expected %0d",
                                                out_data.pages_done, want.pages_done));
                end
                out_hold = out_steady ? 0 : $urandom_range(0, 7);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            out_stall <= (out_hold > 0);
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_count <= 0;
        end else if (quiet_count >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin : stimulus
        int plan_regions [12];
        int ph, k, region, eff, cap, pages, items, roll;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size limits, head and body frees, full region, last start position
        set_region(2047);
        queue_beat(ffpa_pkg::REQ_ALLOC, 0, $urandom);                 // zero bytes
        queue_beat(ffpa_pkg::REQ_ALLOC, 1, $urandom);   // one page after reserved page 0
        queue_beat(ffpa_pkg::REQ_ALLOC, PAGE_SIZE, $urandom);
        queue_beat(ffpa_pkg::REQ_ALLOC, PAGE_SIZE + 1, $urandom);     // rounds up to two pages
        queue_beat(ffpa_pkg::REQ_FREE, $urandom,
                   (3 << ffpa_pkg::PAGE_BITS) | (PAGE_SIZE - 1));
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 4 << ffpa_pkg::PAGE_BITS);  // already free
        queue_beat(ffpa_pkg::REQ_ALLOC, 3 * PAGE_SIZE, $urandom);
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 4 << ffpa_pkg::PAGE_BITS);  // body of a run
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 0);          // page 0 is an ordinary run
        queue_beat(ffpa_pkg::REQ_ALLOC, 1, $urandom);
        queue_beat(ffpa_pkg::REQ_ALLOC, 23'h7FFFFF, $urandom);        // larger than the region
        queue_beat(ffpa_pkg::REQ_ALLOC, ffpa_pkg::TABLE_PAGES * PAGE_SIZE, $urandom);  // no room
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 22'h3FFFFF);
        for (k = 0; k < 4; k++) queue_beat(ffpa_pkg::REQ_FREE, $urandom, k << ffpa_pkg::PAGE_BITS);
        queue_beat(ffpa_pkg::REQ_ALLOC, ffpa_pkg::TABLE_PAGES * PAGE_SIZE, $urandom);  // whole
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 0);
        queue_beat(ffpa_pkg::REQ_ALLOC, 1, $urandom);
        // fits only at the end
        queue_beat(ffpa_pkg::REQ_ALLOC, (ffpa_pkg::TABLE_PAGES - 1) * PAGE_SIZE, $urandom);
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 1 << ffpa_pkg::PAGE_BITS);
        queue_beat(ffpa_pkg::REQ_FREE, $urandom, 0);

        // Random phases over several region sizes, extremes included
        plan_regions = '{1024, 2, 0, 1, 37, 2047, 0, 3, 1025, 128, 16, 1024};
        plan_regions[6] = $urandom_range(2, 2047);
        for (ph = 0; ph < 12; ph++) begin
            region = plan_regions[ph];
            set_region(region);
            eff   = (region < ffpa_pkg::TABLE_PAGES) ? region : ffpa_pkg::TABLE_PAGES;
            cap   = (eff < 1) ? 1 : eff;
            items = (region <= 3) ? 20 : 62;
            for (k = 0; k < items; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    // mostly short runs, now and then one up to the whole region
                    if ($urandom_range(0, 9) == 0) pages = $urandom_range(1, cap);
                    else pages = $urandom_range(1, (cap < 8) ? cap : 8);
                    queue_beat(ffpa_pkg::REQ_ALLOC,
                               (pages - 1) * PAGE_SIZE + $urandom_range(1, PAGE_SIZE),
                               $urandom);
                end else if (roll < 85) begin
                    queue_beat(ffpa_pkg::REQ_FREE, $urandom, 0, 1'b1);
                end else begin
                    queue_beat(1'($urandom_range(0, 1)), $urandom, $urandom);
                end
            end
        end

        wait (pending_q.size() == 0 && due_replies.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("summary: %0d requests over %0d region settings, %0d runs placed, %0d freed",
                 n_requests, n_regions, n_placed, n_released);
        $display("summary: refused %0d for space, %0d for size, %0d bad frees",
                 n_nospace, n_badsize, n_badfree);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/ffpa_engine.sv
rtl/first_fit_page_allocator.sv
bench/testbench.sv
